/* design/fpvt_pkg.sv */
// Package for the flash page validity tracker.
// Holds geometry constants, derived widths and the status and page state codes.
// No dependencies.
package fpvt_pkg;

    localparam int FLASH_COUNT      = 8;
    localparam int BLOCKS_PER_FLASH = 256;
    localparam int PAGES_PER_BLOCK  = 64;

    localparam int NUM_BLOCKS = FLASH_COUNT * BLOCKS_PER_FLASH;
    localparam int BLK_W      = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int PG_W       = (PAGES_PER_BLOCK > 1) ? $clog2(PAGES_PER_BLOCK) : 1;
    localparam int ROW_W      = 2 * PAGES_PER_BLOCK;
    localparam int COUNT_W    = $clog2(PAGES_PER_BLOCK + 1);
    localparam int TYPE_W     = 3;
    localparam int META_W     = TYPE_W + COUNT_W;
    localparam int OUT_CNT_W  = 7;

    localparam logic [1:0] PS_ERASED  = 2'd0;
    localparam logic [1:0] PS_VALID   = 2'd1;
    localparam logic [1:0] PS_INVALID = 2'd2;
    localparam logic [1:0] PS_UNKNOWN = 2'd3;

    localparam logic [1:0] STAT_DONE     = 2'd0;
    localparam logic [1:0] STAT_RANGE    = 2'd1;
    localparam logic [1:0] STAT_BADSTATE = 2'd2;

    localparam logic CMD_SET_PAGE = 1'b0;
    localparam logic CMD_SET_TYPE = 1'b1;

endpackage

/* design/flash_page_validity_tracker_top.sv */
// Top level of the flash page validity tracker.
// Holds the page-row and block metadata memories and their read-modify-write control.
// Depends on fpvt_pkg.

// For each request, the accept cycle issues one read of the block's packed page-state row
// and its count and type, and the next cycle (busy high) modifies and writes them back.
// The result strobe o_valid rises in the cycle after that, the same cycle in which the next
// request may be accepted; the block takes no new request while one is in progress.
// The receiver cannot stall results. After reset the block clears both memories, one block
// per cycle, all NUM_BLOCKS (2048 as configured), with busy high. The empty type code
// may be written at any time and applies to requests accepted at or after the edge that
// writes it.
module flash_page_validity_tracker_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_wdata,
    input  logic        start,
    output logic        busy,
    input  logic        i_cmd,
    input  logic [3:0]  i_flash_index,
    input  logic [8:0]  i_block_index,
    input  logic [6:0]  i_page_index,
    input  logic [1:0]  i_page_state,
    input  logic [2:0]  i_block_type,
    output logic        o_valid,
    output logic [1:0]  o_status,
    output logic [6:0]  o_valid_count,
    output logic [2:0]  o_type_now
);

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_EXEC  = 3'b100
    } t_state;

    t_state r_state, n_state;

    logic [2:0] r_empty_code;

    logic [fpvt_pkg::ROW_W-1:0]  r_row_mem  [fpvt_pkg::NUM_BLOCKS];
    logic [fpvt_pkg::META_W-1:0] r_meta_mem [fpvt_pkg::NUM_BLOCKS];
    logic [fpvt_pkg::ROW_W-1:0]  r_row_q;
    logic [fpvt_pkg::META_W-1:0] r_meta_q;

    logic [fpvt_pkg::BLK_W-1:0] r_clr_cnt;

    logic                       r_cmd;
    logic [fpvt_pkg::BLK_W-1:0] r_blk;
    logic [fpvt_pkg::PG_W-1:0]  r_pg;
    logic [1:0]                 r_ps;
    logic [2:0]                 r_bt;
    logic                       r_range_err;

    logic                       accept;
    logic                       range_err;
    logic [fpvt_pkg::BLK_W-1:0] req_blk;

    logic [fpvt_pkg::COUNT_W-1:0] cur_cnt, n_cnt;
    logic [2:0]                   cur_typ, n_typ;
    logic [1:0]                   old_ps;
    logic [fpvt_pkg::ROW_W-1:0]   n_row;
    logic                         exec_we;
    logic [1:0]                   n_status;
    logic [fpvt_pkg::COUNT_W-1:0] res_cnt;
    logic [2:0]                   res_typ;

    logic                         mem_we;
    logic [fpvt_pkg::BLK_W-1:0]   mem_waddr;
    logic [fpvt_pkg::ROW_W-1:0]   mem_wrow;
    logic [fpvt_pkg::META_W-1:0]  mem_wmeta;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;

    always_comb begin
        range_err = (32'(i_flash_index) >= 32'(fpvt_pkg::FLASH_COUNT)) ||
                    (32'(i_block_index) >= 32'(fpvt_pkg::BLOCKS_PER_FLASH)) ||
                    ((i_cmd == fpvt_pkg::CMD_SET_PAGE) &&
                     (32'(i_page_index) >= 32'(fpvt_pkg::PAGES_PER_BLOCK)));
        req_blk   = fpvt_pkg::BLK_W'(32'(i_flash_index) * 32'(fpvt_pkg::BLOCKS_PER_FLASH) +
                                     32'(i_block_index));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_empty_code <= 3'd0;
        end else if (i_cfg_we) begin
            r_empty_code <= i_cfg_wdata;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr_cnt == fpvt_pkg::BLK_W'(fpvt_pkg::NUM_BLOCKS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC:  n_state = S_IDLE;
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr_cnt <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd       <= i_cmd;
            r_blk       <= req_blk;
            r_pg        <= fpvt_pkg::PG_W'(i_page_index);
            r_ps        <= i_page_state;
            r_bt        <= i_block_type;
            r_range_err <= range_err;
        end
    end

    always_comb begin
        cur_cnt  = r_meta_q[fpvt_pkg::COUNT_W-1:0];
        cur_typ  = r_meta_q[fpvt_pkg::COUNT_W +: fpvt_pkg::TYPE_W];
        old_ps   = r_row_q[{r_pg, 1'b0} +: 2];
        n_row    = r_row_q;
        n_cnt    = cur_cnt;
        n_typ    = cur_typ;
        exec_we  = 1'b0;
        n_status = fpvt_pkg::STAT_DONE;
        if (r_range_err) begin
            n_status = fpvt_pkg::STAT_RANGE;
        end else if (r_cmd == fpvt_pkg::CMD_SET_PAGE) begin
            if (r_ps == fpvt_pkg::PS_UNKNOWN) begin
                n_status = fpvt_pkg::STAT_BADSTATE;
            end else begin
                exec_we = 1'b1;
                n_row[{r_pg, 1'b0} +: 2] = r_ps;
                if (old_ps == fpvt_pkg::PS_VALID && r_ps != fpvt_pkg::PS_VALID &&
                    cur_cnt != '0) begin
                    n_cnt = cur_cnt - 1'b1;
                end else if (old_ps != fpvt_pkg::PS_VALID && r_ps == fpvt_pkg::PS_VALID) begin
                    n_cnt = cur_cnt + 1'b1;
                end
            end
        end else begin
            exec_we = 1'b1;
            n_typ   = r_bt;
            if (r_bt == r_empty_code) begin
                n_row = '0;
                n_cnt = '0;
            end
        end
        res_cnt = r_range_err ? '0 : n_cnt;
        res_typ = r_range_err ? 3'd0 : n_typ;
    end

    always_comb begin
        if (r_state == S_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr_cnt;
            mem_wrow  = '0;
            mem_wmeta = '0;
        end else begin
            mem_we    = (r_state == S_EXEC) && exec_we;
            mem_waddr = r_blk;
            mem_wrow  = n_row;
            mem_wmeta = {n_typ, n_cnt};
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_row_mem[mem_waddr]  <= mem_wrow;
            r_meta_mem[mem_waddr] <= mem_wmeta;
        end
        r_row_q  <= r_row_mem[req_blk];
        r_meta_q <= r_meta_mem[req_blk];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= (r_state == S_EXEC);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_EXEC) begin
            o_status   <= n_status;
            o_type_now <= res_typ;
            if (32'(res_cnt) > 32'd127) begin
                o_valid_count <= 7'd127;
            end else begin
                o_valid_count <= fpvt_pkg::OUT_CNT_W'(res_cnt);
            end
        end
    end

`ifndef SYNTHESIS
    a_result_follows_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_state == S_EXEC))
        else $error("result strobe without a preceding execute cycle");

    a_accept_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (r_state == S_EXEC))
        else $error("accepted request did not enter execute");

    a_range_result_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == fpvt_pkg::STAT_RANGE) |-> (o_valid_count == 7'd0 &&
                                                           o_type_now == 3'd0))
        else $error("out of range result carries nonzero fields");

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (32'(o_valid_count) <= 32'(fpvt_pkg::PAGES_PER_BLOCK)))
        else $error("valid count exceeds pages per block");

    a_no_write_while_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !mem_we)
        else $error("memory written while idle");
`endif

endmodule
